// ===== rtl/lre_pkg.sv =====
// Shared types and codes for the ladder rung evaluator.
// Holds the transaction payload structs, opcodes, block kinds and the slot entry layout.
// No dependencies.
package lre_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    KIND_SHORT = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_NO    = 3'd2,
    KIND_NC    = 3'd3,
    KIND_COIL  = 3'd4
  } kind_e;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  slot;
    logic        slot_valid;
    logic [2:0]  block_kind;
    logic        has_input;
    logic [4:0]  input_select;
    logic [3:0]  grid_row;
    logic [3:0]  grid_col;
    logic [15:0] link_rows;
    logic [31:0] input_bits;
  } in_t;

  typedef struct packed {
    logic is_eval;
    logic energized;
  } out_t;

  // One stored block; the valid flag lives in flip-flops beside the memory.
  typedef struct packed {
    logic [2:0]  kind;
    logic        bound;
    logic [4:0]  sel;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] links;
  } slot_entry_t;

endpackage

// ===== rtl/ladder_rung_evaluator.sv =====
// Ladder rung evaluator: block slot table in a synchronous memory, column-wise reachability.
// A load acknowledgement is valid in the cycle after its transaction is accepted.
// An evaluation scans every slot once per grid column, one memory read per cycle, then
// drains the read pipeline and answers once the output is free; one item at a time.
// Reset (asynchronous, active low) marks all slots empty and clears the control state.
// Depends on lre_pkg.
module ladder_rung_evaluator import lre_pkg::*; #(
  parameter int MAX_SLOTS  = 64,
  parameter int GRID_ROWS  = 16,
  parameter int GRID_COLS  = 16,
  parameter int NUM_INPUTS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_item_o
);

  localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int COL_W   = $clog2(GRID_COLS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  slot_entry_t mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_vld_q;

  slot_entry_t rdata_q;
  logic        rvalid_q;

  logic [SLOT_AW-1:0] slot_cnt_q;
  logic [COL_W-1:0]   col_cnt_q;
  logic               p_vld_q, p_last_q;
  logic [COL_W-1:0]   p_col_q;

  logic [GRID_ROWS-1:0] feed_q, feed_d;
  logic [GRID_ROWS-1:0] next_q, next_d;
  logic                 hit_q, hit_d;
  logic [31:0]          in_bits_q;

  logic out_vld_q;
  out_t out_q;

  logic out_free, accept, do_load, in_range;
  logic [31:0] slot_ext;
  logic [SLOT_AW-1:0] wr_addr;
  logic last_slot, last_col;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && (out_free || in_item_i.opcode == OP_EVAL);
  assign accept     = in_valid_i && in_ready_o;
  assign do_load    = accept && in_item_i.opcode == OP_LOAD;
  assign slot_ext   = 32'(in_item_i.slot);
  assign in_range   = slot_ext < 32'(MAX_SLOTS);
  assign wr_addr    = slot_ext[SLOT_AW-1:0];
  assign last_slot  = slot_cnt_q == SLOT_AW'(MAX_SLOTS - 1);
  assign last_col   = col_cnt_q == COL_W'(GRID_COLS - 1);

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Slot table memory: written by loads in idle, read once per cycle while scanning.
  always_ff @(posedge clk_i) begin
    if (do_load && in_range) begin
      mem[wr_addr] <= '{kind:  in_item_i.block_kind,
                        bound: in_item_i.has_input,
                        sel:   in_item_i.input_select,
                        row:   in_item_i.grid_row,
                        col:   in_item_i.grid_col,
                        links: in_item_i.link_rows};
    end
    rdata_q <= mem[slot_cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rvalid_q   <= 1'b0;
    end else begin
      if (do_load && in_range) begin
        slot_vld_q[wr_addr] <= in_item_i.slot_valid;
      end
      rvalid_q <= slot_vld_q[slot_cnt_q];
    end
  end

  // Decide whether the block read last cycle is reached and passes power on.
  logic        reached, closed, level, row_ok;
  logic [63:0] link_ext;

  always_comb begin
    row_ok   = 32'(rdata_q.row) < 32'(GRID_ROWS);
    reached  = p_vld_q && rvalid_q && row_ok
               && (32'(rdata_q.col) == 32'(p_col_q))
               && (((feed_q >> rdata_q.row) & GRID_ROWS'(1)) != '0);
    level    = rdata_q.bound && (32'(rdata_q.sel) < 32'(NUM_INPUTS))
               && in_bits_q[rdata_q.sel];
    unique case (rdata_q.kind)
      KIND_SHORT: closed = 1'b1;
      KIND_NO:    closed = level;
      KIND_NC:    closed = !level;
      default:    closed = 1'b0;
    endcase
    link_ext = 64'(rdata_q.links);

    hit_d  = hit_q;
    next_d = next_q;
    feed_d = feed_q;
    if (reached) begin
      if (rdata_q.kind == KIND_COIL) begin
        hit_d = 1'b1;
      end else if (closed) begin
        next_d = next_q | link_ext[GRID_ROWS-1:0];
      end
    end
    // At the end of a column its collected links become the next column's feed.
    if (p_vld_q && p_last_q) begin
      feed_d = next_d;
      next_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && in_item_i.opcode == OP_EVAL) state_d = S_RUN;
      S_RUN:   if (last_slot && last_col) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slot_cnt_q <= '0;
      col_cnt_q  <= '0;
      p_vld_q    <= 1'b0;
      p_last_q   <= 1'b0;
      p_col_q    <= '0;
      feed_q     <= '0;
      next_q     <= '0;
      hit_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          p_vld_q <= 1'b0;
          if (accept) begin
            if (in_item_i.opcode == OP_EVAL) begin
              slot_cnt_q <= '0;
              col_cnt_q  <= '0;
              feed_q     <= '1;
              next_q     <= '0;
              hit_q      <= 1'b0;
            end else begin
              out_vld_q <= 1'b1;
            end
          end
        end
        S_RUN: begin
          p_vld_q  <= 1'b1;
          p_last_q <= last_slot;
          p_col_q  <= col_cnt_q;
          feed_q   <= feed_d;
          next_q   <= next_d;
          hit_q    <= hit_d;
          if (last_slot) begin
            slot_cnt_q <= '0;
            col_cnt_q  <= last_col ? '0 : col_cnt_q + COL_W'(1);
          end else begin
            slot_cnt_q <= slot_cnt_q + SLOT_AW'(1);
          end
        end
        S_DRAIN: begin
          p_vld_q <= 1'b0;
          feed_q  <= feed_d;
          next_q  <= next_d;
          hit_q   <= hit_d;
        end
        S_DONE: begin
          p_vld_q <= 1'b0;
          if (out_free) begin
            out_vld_q <= 1'b1;
          end
        end
        default: p_vld_q <= 1'b0;
      endcase
    end
  end

  // Payload registers; the valid flags above say when they matter.
  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.opcode == OP_EVAL) begin
      in_bits_q <= in_item_i.input_bits;
    end
    if (do_load) begin
      out_q <= '{is_eval: 1'b0, energized: 1'b0};
    end else if (state_q == S_DONE && out_free) begin
      out_q <= '{is_eval: 1'b1, energized: hit_q};
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for ladder_rung_evaluator: loads rung block slots, evaluates the rung
// against random input vectors and checks every answer against a local rung predictor.
// Depends on lre_pkg and the ladder_rung_evaluator RTL.
`timescale 1ns / 1ps

module tb;
  import lre_pkg::*;

  localparam int unsigned NUM_SLOTS   = 64;
  localparam int unsigned NUM_COLS    = 16;
  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned QUIET_LIMIT = 10000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned DRAIN_WAIT  = 1100;
  localparam logic [2:0]  KIND_UNDEF  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  // Rung table as the predictor sees it.
  slot_entry_t rung_tbl [NUM_SLOTS];
  logic        rung_used[NUM_SLOTS];

  in_t         stim_q[$];
  out_t        answers_due[$];
  int unsigned err_cnt = 0;

  int unsigned burst_left, gap_left;
  int unsigned seen_cnt, next_hold_at, hold_left, rx_cycle;
  int unsigned quiet_cycles = 0;
  out_t        want;

  ladder_rung_evaluator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #2 clk_i = ~clk_i;

  // Column-wise reachability over the predicted rung table.
  function automatic logic rung_energized(logic [31:0] bits);
    logic [15:0] feed;
    logic [15:0] nxt;
    logic        hit;
    logic        level;
    logic        closed;
    slot_entry_t s;
    feed = '1;
    hit  = 1'b0;
    for (int c = 0; c < NUM_COLS; c++) begin
      nxt = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        s = rung_tbl[i];
        if (rung_used[i] && s.col == c && feed[s.row]) begin
          if (s.kind == KIND_COIL) begin
            hit = 1'b1;
          end else begin
            level = s.bound && bits[s.sel];
            case (s.kind)
              KIND_SHORT: closed = 1'b1;
              KIND_NO:    closed = level;
              KIND_NC:    closed = !level;
              default:    closed = 1'b0;
            endcase
            if (closed) nxt |= s.links;
          end
        end
      end
      feed = nxt;
    end
    return hit;
  endfunction

  task automatic apply_to_rung(in_t it);
    out_t ans;
    if (it.opcode == OP_LOAD) begin
      rung_used[it.slot]      = it.slot_valid;
      rung_tbl[it.slot].kind  = it.block_kind;
      rung_tbl[it.slot].bound = it.has_input;
      rung_tbl[it.slot].sel   = it.input_select;
      rung_tbl[it.slot].row   = it.grid_row;
      rung_tbl[it.slot].col   = it.grid_col;
      rung_tbl[it.slot].links = it.link_rows;
      ans.is_eval   = 1'b0;
      ans.energized = 1'b0;
    end else begin
      ans.is_eval   = 1'b1;
      ans.energized = rung_energized(it.input_bits);
    end
    answers_due.push_back(ans);
  endtask

  function automatic in_t noise_item();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  function automatic in_t load_item(logic [5:0] slot, logic vld, logic [2:0] kind, logic bound,
                                    logic [4:0] sel, logic [3:0] row, logic [3:0] col,
                                    logic [15:0] links);
    in_t it;
    it              = noise_item();
    it.opcode       = OP_LOAD;
    it.slot         = slot;
    it.slot_valid   = vld;
    it.block_kind   = kind;
    it.has_input    = bound;
    it.input_select = sel;
    it.grid_row     = row;
    it.grid_col     = col;
    it.link_rows    = links;
    return it;
  endfunction

  function automatic in_t eval_item(logic [31:0] bits);
    in_t it;
    it            = noise_item();
    it.opcode     = OP_EVAL;
    it.input_bits = bits;
    return it;
  endfunction

  function automatic logic [2:0] pick_contact();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return KIND_SHORT;
    if (r < 5) return KIND_NO;
    if (r < 8) return KIND_NC;
    if (r < 9) return KIND_OPEN;
    return 3'(KIND_COIL + $urandom_range(1, 3));
  endfunction

  function automatic logic [31:0] pick_inputs();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Stimulus generation: a directed prologue, then rung programs followed by evaluations.
  task automatic build_stimulus();
    int unsigned r, ncols, nrows, base, nblk, neval, first, cnt;
    logic        deep;
    logic [3:0]  col;
    logic [2:0]  kind;
    logic [15:0] links;

    stim_q.push_back(eval_item('1));                                   // empty rung
    stim_q.push_back(load_item(6'd0, 1'b1, KIND_NO, 1'b1, 5'd0, 4'd0, 4'd0, 16'h0001));
    stim_q.push_back(load_item(6'd63, 1'b1, KIND_COIL, 1'b0, 5'd31, 4'd0, 4'd1, 16'hFFFF));
    stim_q.push_back(eval_item(32'h0000_0000));
    stim_q.push_back(eval_item(32'h0000_0001));
    stim_q.push_back(load_item(6'd0, 1'b1, KIND_NC, 1'b1, 5'd31, 4'd0, 4'd0, 16'h0001));
    stim_q.push_back(eval_item('1));
    stim_q.push_back(eval_item(32'h7FFF_FFFF));
    // An unbound contact sees false, so a normally open one stays open.
    stim_q.push_back(load_item(6'd0, 1'b1, KIND_NO, 1'b0, 5'd0, 4'd0, 4'd0, 16'h0001));
    stim_q.push_back(eval_item('1));
    stim_q.push_back(load_item(6'd0, 1'b1, KIND_UNDEF, 1'b1, 5'd0, 4'd0, 4'd0, 16'hFFFF));
    stim_q.push_back(eval_item('1));
    stim_q.push_back(load_item(6'd0, 1'b1, KIND_SHORT, 1'b0, 5'd0, 4'd0, 4'd0, 16'h8000));
    stim_q.push_back(load_item(6'd63, 1'b1, KIND_COIL, 1'b1, 5'd0, 4'd15, 4'd1, 16'h0000));
    stim_q.push_back(eval_item('0));
    stim_q.push_back(load_item(6'd0, 1'b1, KIND_OPEN, 1'b1, 5'd0, 4'd0, 4'd0, 16'hFFFF));
    stim_q.push_back(eval_item('1));
    // A coil placed in column 0 is reached directly; emptying its slot removes it.
    stim_q.push_back(load_item(6'd2, 1'b1, KIND_COIL, 1'b0, 5'd0, 4'd7, 4'd0, 16'h0000));
    stim_q.push_back(eval_item('0));
    stim_q.push_back(load_item(6'd2, 1'b0, KIND_COIL, 1'b0, 5'd0, 4'd7, 4'd0, 16'h0000));
    // Links out of the last column lead nowhere.
    stim_q.push_back(load_item(6'd3, 1'b1, KIND_SHORT, 1'b1, 5'd31, 4'd15, 4'd15, 16'hFFFF));
    stim_q.push_back(eval_item('0));

    while (stim_q.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        stim_q.push_back(noise_item());
      end else if (r < 20) begin
        // Empty a run of slots so stale blocks do not pile up.
        first = $urandom_range(0, NUM_SLOTS - 1);
        cnt   = $urandom_range(4, 16);
        for (int k = 0; k < cnt; k++) begin
          stim_q.push_back(load_item(6'((first + k) % NUM_SLOTS), 1'b0, pick_contact(),
                                     1'($urandom()), 5'($urandom()), 4'($urandom()),
                                     4'($urandom()), 16'($urandom())));
        end
        if ($urandom_range(0, 1) == 0) stim_q.push_back(eval_item(pick_inputs()));
      end else begin
        deep  = ($urandom_range(0, 7) == 0);
        ncols = deep ? NUM_COLS - 1 : $urandom_range(1, 4);
        nrows = deep ? 1 : $urandom_range(1, 4);
        nblk  = deep ? NUM_COLS : $urandom_range(3, 10);
        base  = $urandom_range(0, NUM_SLOTS - 1);
        for (int k = 0; k < nblk; k++) begin
          if (k == nblk - 1) begin
            col  = 4'(ncols);
            kind = KIND_COIL;
          end else begin
            col  = deep ? 4'(k) : 4'($urandom_range(0, ncols - 1));
            kind = (deep && $urandom_range(0, 4) != 0) ? KIND_SHORT : pick_contact();
          end
          links = 16'($urandom_range(1, (1 << nrows) - 1));
          if ($urandom_range(0, 3) == 0) links |= 16'($urandom());
          stim_q.push_back(load_item(6'((base + k) % NUM_SLOTS), 1'b1, kind,
                                     ($urandom_range(0, 7) != 0), 5'($urandom()),
                                     4'($urandom_range(0, nrows - 1)), col, links));
        end
        neval = $urandom_range(1, 4);
        for (int k = 0; k < neval; k++) stim_q.push_back(eval_item(pick_inputs()));
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_item    <= '0;
      burst_left <= $urandom_range(1, 16);
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) apply_to_rung(in_item);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (stim_q.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= stim_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transaction and stalls on a rotating pattern, with long hold-offs.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      seen_cnt     = 0;
      next_hold_at = 100;
      hold_left    = 0;
      rx_cycle     = 0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) begin
        seen_cnt++;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual is_eval=%0b energized=%0b",
                   $time, out_item.is_eval, out_item.energized);
          err_cnt++;
        end else begin
          want = answers_due.pop_front();
          if (out_item.is_eval !== want.is_eval) begin
            $display("%0t: is_eval mismatch: expected %0b, actual %0b",
                     $time, want.is_eval, out_item.is_eval);
            err_cnt++;
          end
          if (out_item.energized !== want.energized) begin
            $display("%0t: energized mismatch: expected %0b, actual %0b",
                     $time, want.energized, out_item.energized);
            err_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (seen_cnt >= next_hold_at) begin
        // Long hold-off, longer than an evaluation, so the block fills up and pushes back.
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        next_hold_at += 400;
      end else begin
        case ((rx_cycle >> 7) % 3)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rung_used[i] = 1'b0;
      rung_tbl[i]  = '0;
    end
    build_stimulus();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    while (stim_q.size() != 0 || in_valid || answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lre_pkg.sv
rtl/ladder_rung_evaluator.sv
bench/tb.sv
